// ----- hdl/acr_pkg.sv -----
// Shared types, constants and arithmetic helpers of the allpass/comb reverb.
`default_nettype none
package acr_pkg;

  // Default number of entries in each delay line
  localparam int ACR_MAX_DELAY_DEF = 65536;

  // Datapath widths: multiplier operands, product and accumulator
  localparam int MUL_A_W = 21;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 54;

  // Line numbering: allpass a, b, c then comb a, b, c, d
  localparam int          NUM_LINES  = 7;
  localparam logic [2:0]  LINE_COMB0 = 3'd3;
  localparam logic [2:0]  LINE_LAST  = 3'd6;

  // Clip and saturation limits at accumulator width
  localparam logic signed [ACC_W-1:0] CLIP_HI = 32767;
  localparam logic signed [ACC_W-1:0] CLIP_LO = -32767;
  localparam logic signed [ACC_W-1:0] SAT_HI  = 524287;
  localparam logic signed [ACC_W-1:0] SAT_LO  = -524288;
  localparam logic signed [ACC_W-1:0] HALF_15 = 16384;
  localparam logic signed [ACC_W-1:0] HALF_30 = 536870912;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_WET_MIX     = 3'd0,
    REG_AP_GAIN     = 3'd1,
    REG_COMB_GAIN_1 = 3'd2,
    REG_COMB_GAIN_2 = 3'd3,
    REG_COMB_GAIN_3 = 3'd4,
    REG_COMB_GAIN_4 = 3'd5,
    REG_ROOM_SCALE  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]      wet_mix;
    logic [14:0]      allpass_gain;
    logic [3:0][14:0] comb_gain;
    logic [12:0]      room_scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    wet_mix:      16'd0,
    allpass_gain: 15'd22938,
    comb_gain:    {15'd24019, 15'd24674, 15'd26280, 15'd25330},
    room_scale:   13'd256
  };

  // Multiplier operand pairs
  typedef enum logic [3:0] {
    M_NONE  = 4'd0,
    M_GG    = 4'd1,
    M_LEN   = 4'd2,
    M_GX    = 4'd3,
    M_CURK  = 4'd4,
    M_GHK   = 4'd5,
    M_GLK   = 4'd6,
    M_GPREV = 4'd7,
    M_CGX   = 4'd8,
    M_CGCUR = 4'd9,
    M_WS    = 4'd10,
    M_WD    = 4'd11
  } mop_t;

  // Accumulator operations on the registered product
  typedef enum logic [2:0] {
    A_HOLD     = 3'd0,
    A_LOAD     = 3'd1,
    A_LOAD_S15 = 3'd2,
    A_SUB      = 3'd3,
    A_SUB_S16  = 3'd4,
    A_ADD      = 3'd5,
    A_LOAD_GX  = 3'd6
  } aop_t;

  // Controller to datapath
  typedef struct packed {
    mop_t       mop;
    aop_t       aop;
    logic       clr;
    logic       ld_in;
    logic       cap_kq;
    logic       cap_len;
    logic       rd_prev;
    logic       cap_gx;
    logic       cap_cur;
    logic       cap_prev;
    logic       cap_y;
    logic       wr_ap;
    logic       wr_cb;
    logic       emit;
    logic [2:0] line;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

  // Base delay lengths of the seven lines
  function automatic logic [11:0] base_len(input logic [2:0] k);
    logic [11:0] r;
    unique case (k)
      3'd0:    r = 12'd347;
      3'd1:    r = 12'd113;
      3'd2:    r = 12'd37;
      3'd3:    r = 12'd1687;
      3'd4:    r = 12'd1601;
      3'd5:    r = 12'd2053;
      3'd6:    r = 12'd2251;
      default: r = 12'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] clip16(input logic signed [ACC_W-1:0] v);
    logic signed [15:0] r;
    if (v > CLIP_HI)      r = 16'sd32767;
    else if (v < CLIP_LO) r = -16'sd32767;
    else                  r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [ACC_W-1:0] v);
    logic signed [19:0] r;
    if (v > SAT_HI)      r = 20'sh7FFFF;
    else if (v < SAT_LO) r = 20'sh80000;
    else                 r = v[19:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/acr_if.sv -----
// Channel interfaces: input sample pair, mixed result and configuration writes.
`default_nettype none
interface acr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  modport source(output valid, left_sample, right_sample, input ready);
  modport sink(input valid, left_sample, right_sample, output ready);
endinterface

interface acr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mixed_sample;
  modport source(output valid, mixed_sample, input ready);
  modport sink(input valid, mixed_sample, output ready);
endinterface

interface acr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/acr_ctrl.sv -----
// Sequencer of the reverb: steps the shared multiplier and line memories per sample.
`default_nettype none
module acr_ctrl import acr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [24:0] {
    S_CLEAR  = 25'd1 << 0,
    S_IDLE   = 25'd1 << 1,
    S_KQ1    = 25'd1 << 2,
    S_KQ2    = 25'd1 << 3,
    S_KQ3    = 25'd1 << 4,
    S_LEN1   = 25'd1 << 5,
    S_LEN2   = 25'd1 << 6,
    S_LEN3   = 25'd1 << 7,
    S_AP_RD  = 25'd1 << 8,
    S_AP_RP  = 25'd1 << 9,
    S_AP_M1  = 25'd1 << 10,
    S_AP_M2  = 25'd1 << 11,
    S_AP_M3  = 25'd1 << 12,
    S_AP_M4  = 25'd1 << 13,
    S_AP_M5  = 25'd1 << 14,
    S_AP_WR  = 25'd1 << 15,
    S_CB_RD  = 25'd1 << 16,
    S_CB_M1  = 25'd1 << 17,
    S_CB_M2  = 25'd1 << 18,
    S_CB_M3  = 25'd1 << 19,
    S_CB_WR  = 25'd1 << 20,
    S_MX1    = 25'd1 << 21,
    S_MX2    = 25'd1 << 22,
    S_MX3    = 25'd1 << 23,
    S_MX4    = 25'd1 << 24
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] line_r, line_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      line_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      line_r  <= line_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    line_nxt  = line_r;
    cmd       = '0;
    cmd.line  = line_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          line_nxt  = 3'd0;
          state_nxt = S_KQ1;
        end
      end
      // 1 - g*g, shared by the three allpass stages
      S_KQ1: begin cmd.mop = M_GG; state_nxt = S_KQ2; end
      S_KQ2: begin cmd.aop = A_LOAD; state_nxt = S_KQ3; end
      S_KQ3: begin cmd.cap_kq = 1'b1; state_nxt = S_LEN1; end
      // line length and start position
      S_LEN1: begin cmd.mop = M_LEN; state_nxt = S_LEN2; end
      S_LEN2: begin cmd.aop = A_LOAD; state_nxt = S_LEN3; end
      S_LEN3: begin
        cmd.cap_len = 1'b1;
        state_nxt   = (line_r < LINE_COMB0) ? S_AP_RD : S_CB_RD;
      end
      // allpass stage
      S_AP_RD: begin cmd.mop = M_GX; state_nxt = S_AP_RP; end
      S_AP_RP: begin
        cmd.rd_prev = 1'b1;
        cmd.cap_gx  = 1'b1;
        cmd.cap_cur = 1'b1;
        state_nxt   = S_AP_M1;
      end
      S_AP_M1: begin cmd.cap_prev = 1'b1; cmd.mop = M_CURK; state_nxt = S_AP_M2; end
      S_AP_M2: begin cmd.mop = M_GHK; cmd.aop = A_LOAD_S15; state_nxt = S_AP_M3; end
      S_AP_M3: begin cmd.mop = M_GLK; cmd.aop = A_SUB_S16; state_nxt = S_AP_M4; end
      S_AP_M4: begin cmd.mop = M_GPREV; cmd.aop = A_SUB; state_nxt = S_AP_M5; end
      S_AP_M5: begin cmd.cap_y = 1'b1; cmd.aop = A_LOAD_GX; state_nxt = S_AP_WR; end
      S_AP_WR: begin
        cmd.wr_ap = 1'b1;
        line_nxt  = line_r + 3'd1;
        state_nxt = S_LEN1;
      end
      // comb stage
      S_CB_RD: begin cmd.mop = M_CGX; state_nxt = S_CB_M1; end
      S_CB_M1: begin cmd.cap_cur = 1'b1; cmd.aop = A_LOAD; state_nxt = S_CB_M2; end
      S_CB_M2: begin cmd.mop = M_CGCUR; state_nxt = S_CB_M3; end
      S_CB_M3: begin cmd.aop = A_ADD; state_nxt = S_CB_WR; end
      S_CB_WR: begin
        cmd.wr_cb = 1'b1;
        if (line_r == LINE_LAST) begin
          state_nxt = S_MX1;
        end else begin
          line_nxt  = line_r + 3'd1;
          state_nxt = S_LEN1;
        end
      end
      // dry/wet mix
      S_MX1: begin cmd.mop = M_WS; state_nxt = S_MX2; end
      S_MX2: begin cmd.mop = M_WD; cmd.aop = A_LOAD; state_nxt = S_MX3; end
      S_MX3: begin cmd.aop = A_ADD; state_nxt = S_MX4; end
      S_MX4: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/acr_dp.sv -----
// Reverb datapath: shared multiplier, accumulator, delay line memories, output register.
`default_nettype none
module acr_dp import acr_pkg::*; #(
  parameter int MAX_DELAY = ACR_MAX_DELAY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic signed [15:0] left_sample,
  input  wire logic signed [15:0] right_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      mixed_sample
);

  localparam int AW = $clog2(MAX_DELAY);
  localparam int LW = $clog2(MAX_DELAY + 1);

  logic signed [15:0]        dry_r, x_r, y_r, sum_r, out_r;
  logic [16:0]               kq_r;
  logic [LW-1:0]             len_r;
  logic [AW-1:0]             pos_r;
  logic [AW-1:0]             pos_tab_r [NUM_LINES];
  logic signed [31:0]        gx_r;
  logic signed [19:0]        cur_r, prev_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      out_valid_r;
  logic [AW-1:0]             clr_cnt_r;

  // Operand helpers
  logic [2:0]         cidx3;
  logic [1:0]         cidx;
  logic [14:0]        gc;
  logic [16:0]        wet_w, dry_w;
  logic signed [15:0] gx_hi;
  logic signed [16:0] in_sum;

  assign cidx3  = cmd.line - LINE_COMB0;
  assign cidx   = cidx3[1:0];
  assign gc     = cfg.comb_gain[cidx];
  assign wet_w  = (cfg.wet_mix > 16'd32768) ? 17'd32768 : {1'b0, cfg.wet_mix};
  assign dry_w  = 17'd32768 - wet_w;
  assign gx_hi  = gx_r[31:16];
  assign in_sum = 17'(left_sample) + 17'(right_sample);

  // Shared multiplier, product registered
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mop)
      M_GG:    begin mul_a = {6'd0, cfg.allpass_gain}; mul_b = {3'd0, cfg.allpass_gain}; end
      M_LEN:   begin mul_a = {9'd0, base_len(cmd.line)}; mul_b = {5'd0, cfg.room_scale}; end
      M_GX:    begin mul_a = MUL_A_W'(x_r); mul_b = {3'd0, cfg.allpass_gain}; end
      M_CURK:  begin mul_a = MUL_A_W'(cur_r); mul_b = {1'b0, kq_r}; end
      M_GHK:   begin mul_a = MUL_A_W'(gx_hi); mul_b = {1'b0, kq_r}; end
      M_GLK:   begin mul_a = {5'd0, gx_r[15:0]}; mul_b = {1'b0, kq_r}; end
      M_GPREV: begin mul_a = MUL_A_W'(prev_r); mul_b = {3'd0, cfg.allpass_gain}; end
      M_CGX:   begin mul_a = MUL_A_W'(x_r); mul_b = {3'd0, gc}; end
      M_CGCUR: begin mul_a = MUL_A_W'(cur_r); mul_b = {3'd0, gc}; end
      M_WS:    begin mul_a = MUL_A_W'(sum_r); mul_b = {1'b0, wet_w}; end
      M_WD:    begin mul_a = MUL_A_W'(dry_r); mul_b = {1'b0, dry_w}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Accumulator
  logic signed [ACC_W-1:0] prod_ext;
  assign prod_ext = ACC_W'(prod_r);

  always_comb begin
    unique case (cmd.aop)
      A_HOLD:     acc_nxt = acc_r;
      A_LOAD:     acc_nxt = prod_ext;
      A_LOAD_S15: acc_nxt = prod_ext <<< 15;
      A_SUB:      acc_nxt = acc_r - prod_ext;
      A_SUB_S16:  acc_nxt = acc_r - (prod_ext <<< 16);
      A_ADD:      acc_nxt = acc_r + prod_ext;
      A_LOAD_GX:  acc_nxt = prod_ext + ACC_W'(gx_r);
      default:    acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Rounded views of the accumulator (round half up)
  logic signed [ACC_W-1:0] rnd15, rnd30;
  logic signed [15:0]      yc;
  assign rnd15 = (acc_r + HALF_15) >>> 15;
  assign rnd30 = (acc_r + HALF_30) >>> 30;
  assign yc    = clip16(rnd15);

  // Line length, clamped to 1..MAX_DELAY, and start position
  logic [ACC_W-9:0] len_raw;
  logic [LW-1:0]    len_new;
  logic [AW-1:0]    pos_take;
  assign len_raw = acc_r[ACC_W-1:8];

  always_comb begin
    if (len_raw > (ACC_W-8)'(MAX_DELAY)) len_new = LW'(MAX_DELAY);
    else if (len_raw == '0)              len_new = LW'(1);
    else                                 len_new = len_raw[LW-1:0];
    pos_take = (LW'(pos_tab_r[cmd.line]) >= len_new) ? '0 : pos_tab_r[cmd.line];
  end

  // Previous and following positions
  logic [AW-1:0] prev_addr, pos_adv;
  logic [LW-1:0] pos_inc;
  logic [LW-1:0] len_dec;
  assign len_dec   = len_r - LW'(1);
  assign prev_addr = (pos_r == '0) ? len_dec[AW-1:0] : pos_r - AW'(1);
  assign pos_inc   = LW'(pos_r) + LW'(1);
  assign pos_adv   = (pos_inc >= len_r) ? '0 : pos_inc[AW-1:0];

  // Delay line memories, one address for all, read data registered
  logic [AW-1:0]      mem_addr;
  logic signed [19:0] ap_wdata;
  logic signed [19:0] rd_ap [3];
  logic signed [15:0] rd_cb [4];
  logic signed [19:0] rd_sel;

  assign mem_addr = cmd.clr ? clr_cnt_r : (cmd.rd_prev ? prev_addr : pos_r);
  assign ap_wdata = sat20(rnd15);

  for (genvar j = 0; j < 3; j++) begin : g_ap
    logic signed [19:0] mem [MAX_DELAY];
    logic               we;
    assign we = cmd.clr || (cmd.wr_ap && (cmd.line == 3'(j)));
    always_ff @(posedge clk) begin
      if (we) mem[mem_addr] <= cmd.clr ? 20'sd0 : ap_wdata;
      rd_ap[j] <= mem[mem_addr];
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_cb
    logic signed [15:0] mem [MAX_DELAY];
    logic               we;
    assign we = cmd.clr || (cmd.wr_cb && (cmd.line == 3'(j + 3)));
    always_ff @(posedge clk) begin
      if (we) mem[mem_addr] <= cmd.clr ? 16'sd0 : x_r;
      rd_cb[j] <= mem[mem_addr];
    end
  end

  assign rd_sel = (cmd.line < LINE_COMB0) ? rd_ap[cmd.line[1:0]] : 20'(rd_cb[cidx]);

  // Running comb sum with clipping after each addition
  logic signed [15:0] sum_add;
  assign sum_add = clip16(ACC_W'(sum_r) + ACC_W'(yc));

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      dry_r <= in_sum[16:1];
      x_r   <= in_sum[16:1];
    end
    if (cmd.cap_kq)   kq_r   <= 17'd32768 - rnd15[16:0];
    if (cmd.cap_len) begin
      len_r <= len_new;
      pos_r <= pos_take;
    end
    if (cmd.cap_gx)   gx_r   <= prod_r[31:0];
    if (cmd.cap_cur)  cur_r  <= rd_sel;
    if (cmd.cap_prev) prev_r <= rd_sel;
    if (cmd.cap_y)    y_r    <= clip16(rnd30);
    if (cmd.wr_ap)    x_r    <= y_r;
    if (cmd.wr_cb)    sum_r  <= (cmd.line == LINE_COMB0) ? yc : sum_add;
    if (cmd.emit)     out_r  <= yc;
  end

  // Control state: positions, clearing sweep, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LINES; i++) pos_tab_r[i] <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.wr_ap || cmd.wr_cb) pos_tab_r[cmd.line] <= pos_adv;
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.emit)     out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign sts.clr_last  = (clr_cnt_r == AW'(MAX_DELAY - 1));
  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign mixed_sample  = out_r;

`ifndef SYNTHESIS
  // A freshly computed length is always usable
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_len |=> (len_r != '0) && (len_r <= LW'(MAX_DELAY)))
    else $error("line length out of range");

  // Start position lies inside the line
  a_pos_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_len |=> (LW'(pos_r) < len_r))
    else $error("line position beyond length");

  // A result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result dropped");
`endif

endmodule
`default_nettype wire

// ----- hdl/allpass_comb_reverb.sv -----
// Top level of the allpass/comb reverb: configuration registers, sequencer and datapath.
//
// Usage:
//   in_ch   takes a stereo pair (left_sample, right_sample); a transfer is one sample.
//   out_ch  gives one mixed_sample per input transfer, in order.
//   cfg_ch  writes register <index> with <data>; always ready. Write only while idle.
// Timing:
//   After reset the seven delay lines are cleared in a sweep over all MAX_DELAY entries,
//   during which in_ch.ready stays low.
//   A sample is worked on in steps after its transfer: eleven steps per allpass
//   stage, eight per comb stage (both counting the length step), three for the gain
//   term and four for the mix, all through one shared multiplier. out_ch.valid rises
//   when the final mix step loads the result into the output register.
//   in_ch.ready returns in the same cycle as out_ch.valid, so a new sample is taken
//   only after the result of the previous one has been issued.
// Backpressure:
//   A finished result waits in the output register; the next sample is still accepted
//   and processed, and its final step holds until the previous result has been taken.
`default_nettype none
module allpass_comb_reverb import acr_pkg::*; #(
  parameter int MAX_DELAY = ACR_MAX_DELAY_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  acr_in_if.sink    in_ch,
  acr_out_if.source out_ch,
  acr_cfg_if.sink   cfg_ch
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_WET_MIX:     cfg_r.wet_mix      <= cfg_ch.data;
        REG_AP_GAIN:     cfg_r.allpass_gain <= cfg_ch.data[14:0];
        REG_COMB_GAIN_1: cfg_r.comb_gain[0] <= cfg_ch.data[14:0];
        REG_COMB_GAIN_2: cfg_r.comb_gain[1] <= cfg_ch.data[14:0];
        REG_COMB_GAIN_3: cfg_r.comb_gain[2] <= cfg_ch.data[14:0];
        REG_COMB_GAIN_4: cfg_r.comb_gain[3] <= cfg_ch.data[14:0];
        REG_ROOM_SCALE:  cfg_r.room_scale   <= cfg_ch.data[12:0];
        default: ;
      endcase
    end
  end

  acr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  acr_dp #(
    .MAX_DELAY (MAX_DELAY)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .cmd          (cmd),
    .sts          (sts),
    .left_sample  (in_ch.left_sample),
    .right_sample (in_ch.right_sample),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .mixed_sample (out_ch.mixed_sample)
  );

endmodule
`default_nettype wire
